// ----- sv/pht_pkg.sv -----
// Shared types and constants for the pairing handshake peer table.
`timescale 1ns / 1ps
`default_nettype none
package pht_pkg;
   localparam int MAX_PEERS      = 16;
   localparam int IDX_W          = $clog2(MAX_PEERS);
   localparam int CNT_W          = $clog2(MAX_PEERS + 1);
   localparam logic [7:0] BROADCAST_ADDR = 8'd255;
   localparam logic [31:0] DEFAULT_TIMEOUT = 32'd5000;

   // operation codes
   localparam logic [2:0] OP_FRAME  = 3'd0;
   localparam logic [2:0] OP_PAIR   = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_POLL   = 3'd4;

   // frame types
   localparam logic [1:0] FT_REQ  = 2'd0;
   localparam logic [1:0] FT_RESP = 2'd1;
   localparam logic [1:0] FT_CONF = 2'd2;

   // pairing states
   localparam logic [1:0] PS_NONE     = 2'd0;
   localparam logic [1:0] PS_PENDING  = 2'd1;
   localparam logic [1:0] PS_COMPLETE = 2'd2;

   // result kinds
   localparam logic [1:0] RK_STATUS = 2'd0;
   localparam logic [1:0] RK_TX     = 2'd1;
   localparam logic [1:0] RK_EVENT  = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_STATE = 3'd1;
   localparam logic [2:0] ST_BAD_ARG   = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   // register indexes
   localparam logic [7:0] REG_ROLE    = 8'd0;
   localparam logic [7:0] REG_OWN     = 8'd1;
   localparam logic [7:0] REG_TIMEOUT = 8'd2;
   localparam logic [7:0] REG_LIMIT   = 8'd3;
   localparam logic [7:0] REG_MIN     = 8'd4;
   localparam logic [7:0] REG_MAX     = 8'd5;

   typedef struct packed {
      logic [7:0]  addr;
      logic [1:0]  pstate;
      logic [31:0] since;
      logic        online;
      logic [31:0] heartbeat;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
endpackage
`default_nettype wire

// ----- sv/pht_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ----- sv/pairing_handshake_table_top.sv -----
// Top level of the pairing handshake peer table: sequencer, registers, outputs.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps up to sixteen peers in a packed table held in one synchronous
// RAM and runs a request/response/confirm pairing handshake as master or slave.
// Each request yields zero or more transmit and pairing-event results followed
// by exactly one final status result marked by rsp_tlast. One request at a time
// is worked on: a lookup walks the table entry by entry (RAM read, then
// compare), remove shifts later entries down by a read and a write each, and a
// poll visits every stored entry and emits an event for each pairing that
// lapses. Results are held while rsp_tready is low. Clearing all peers and
// reset only zero the fill count, so no RAM clearing pass is needed.
// Configuration writes are always taken (csr_ready is high) and must only be
// issued while the block is idle.
module pairing_handshake_table_top
   import pht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] frame_type, [9:2] frame_src, [17:10] frame_dest,
   // [25:18] target_addr, [57:26] now_time, rest zero
   input  wire logic [63:0] req_tdata,
   // [2:0] operation
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] tx_dest, [9:8] tx_type, [17:10] tx_seq, [25:18] event_addr,
   // [26] event_paired, [29:27] status, rest zero
   output logic [31:0]      rsp_tdata,
   // [1:0] result_kind
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_FIND  = 11'b00000000010,
      S_FCHK  = 11'b00000000100,
      S_ACT   = 11'b00000001000,
      S_SREAD = 11'b00000010000,
      S_SWR   = 11'b00000100000,
      S_PREAD = 11'b00001000000,
      S_PCHK  = 11'b00010000000,
      S_ETX   = 11'b00100000000,
      S_EEV   = 11'b01000000000,
      S_FIN   = 11'b10000000000
   } state_type;

   // configuration
   logic        role_ff;
   logic [7:0]  own_ff;
   logic [31:0] timeout_ff;
   logic [4:0]  limit_ff;
   logic [7:0]  amin_ff, amax_ff;

   // sequencer state
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [7:0]       seq_ff, seq_in;
   logic [2:0]       op_ff, op_in;
   logic [1:0]       ftype_ff, ftype_in;
   logic [7:0]       key_ff, key_in;
   logic [31:0]      now_ff, now_in;
   logic [2:0]       status_ff, status_in;
   logic             found_ff, found_in;
   logic [1:0]       txtype_ff, txtype_in;
   logic             doev_ff, doev_in;
   logic [7:0]       evaddr_ff, evaddr_in;
   logic             evpaired_ff, evpaired_in;

   // result register
   logic        ovalid_ff, ovalid_in;
   logic [31:0] odata_ff, odata_in;
   logic [1:0]  okind_ff, okind_in;
   logic        olast_ff, olast_in;

   // RAM access
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type        wr_entry, rd_entry;
   logic [ENTRY_W-1:0] rd_bits;

   pht_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PEERS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );
   assign rd_entry = entry_type'(rd_bits);

   logic [CNT_W-1:0] lim;
   logic [CNT_W-1:0] idx_next;
   logic             out_free;
   logic [31:0]      tmo;
   logic [31:0]      age;
   logic             can_add;
   logic             frame_go;
   logic [7:0]       r_src, r_dest, r_target;
   logic [1:0]       r_type;

   // effective limit: min(peer_limit, MAX_PEERS)
   assign lim = (CNT_W'(limit_ff) > CNT_W'(MAX_PEERS)) ? CNT_W'(MAX_PEERS)
                                                       : CNT_W'(limit_ff);
   assign idx_next = idx_ff + CNT_W'(1);
   assign out_free = !ovalid_ff || rsp_tready;
   assign tmo      = (timeout_ff == 32'd0) ? DEFAULT_TIMEOUT : timeout_ff;
   assign age      = now_ff - rd_entry.since;
   assign can_add  = count_ff < lim;

   assign r_type   = req_tdata[1:0];
   assign r_src    = req_tdata[9:2];
   assign r_dest   = req_tdata[17:10];
   assign r_target = req_tdata[25:18];

   // decide whether a received frame is worth a table lookup
   always_comb begin
      unique case (r_type)
         FT_REQ:  frame_go = role_ff && (r_dest == own_ff || r_dest == BROADCAST_ADDR);
         FT_RESP: frame_go = !role_ff;
         FT_CONF: frame_go = role_ff;
         default: frame_go = 1'b0;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      seq_in      = seq_ff;
      op_in       = op_ff;
      ftype_in    = ftype_ff;
      key_in      = key_ff;
      now_in      = now_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      txtype_in   = txtype_ff;
      doev_in     = doev_ff;
      evaddr_in   = evaddr_ff;
      evpaired_in = evpaired_ff;
      ovalid_in   = ovalid_ff && !rsp_tready;
      odata_in    = odata_ff;
      okind_in    = okind_ff;
      olast_in    = olast_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff[IDX_W-1:0];
      wr_entry    = rd_entry;
      rd_en       = 1'b0;
      rd_addr     = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               ftype_in  = r_type;
               now_in    = req_tdata[57:26];
               status_in = ST_OK;
               doev_in   = 1'b0;
               idx_in    = '0;
               state_in  = S_FIN;
               unique case (req_tuser)
                  OP_FRAME: begin
                     key_in = r_src;
                     if (frame_go) state_in = S_FIND;
                  end
                  OP_PAIR: begin
                     key_in = r_target;
                     priority if (role_ff) status_in = ST_BAD_STATE;
                     else if (r_target < amin_ff || r_target > amax_ff)
                        status_in = ST_BAD_ARG;
                     else if (!can_add) status_in = ST_FULL;
                     else state_in = S_FIND;
                  end
                  OP_REMOVE: begin
                     key_in   = r_target;
                     state_in = S_FIND;
                  end
                  OP_CLEAR: count_in = '0;
                  OP_POLL:  state_in = S_PREAD;
                  default:  status_in = ST_BAD_ARG;
               endcase
            end
         end
         S_FIND: begin
            // walk the packed table; past the fill count means absent
            if (idx_ff >= count_ff) begin
               found_in = 1'b0;
               state_in = S_ACT;
            end else begin
               rd_en    = 1'b1;
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            if (rd_entry.addr == key_ff) begin
               found_in = 1'b1;
               state_in = S_ACT;
            end else begin
               idx_in   = idx_next;
               state_in = S_FIND;
            end
         end
         S_ACT: begin
            evaddr_in   = key_ff;
            evpaired_in = 1'b1;
            state_in    = S_FIN;
            if (!found_ff) begin
               wr_addr  = count_ff[IDX_W-1:0];
               wr_entry = '{addr: key_ff, pstate: PS_NONE, since: '0,
                            online: 1'b0, heartbeat: '0};
            end
            unique case (op_ff)
               OP_FRAME: begin
                  unique case (ftype_ff)
                     FT_REQ: begin
                        if (found_ff || can_add) begin
                           wr_en           = 1'b1;
                           wr_entry.pstate = PS_PENDING;
                           wr_entry.since  = now_ff;
                           if (!found_ff) count_in = count_ff + CNT_W'(1);
                           txtype_in = FT_RESP;
                           state_in  = S_ETX;
                        end
                     end
                     FT_RESP: begin
                        if (found_ff && rd_entry.pstate == PS_PENDING) begin
                           wr_en              = 1'b1;
                           wr_entry.pstate    = PS_COMPLETE;
                           wr_entry.online    = 1'b1;
                           wr_entry.heartbeat = now_ff;
                           txtype_in = FT_CONF;
                           doev_in   = 1'b1;
                           state_in  = S_ETX;
                        end
                     end
                     FT_CONF: begin
                        if (found_ff) begin
                           wr_en              = 1'b1;
                           wr_entry.pstate    = PS_COMPLETE;
                           wr_entry.online    = 1'b1;
                           wr_entry.heartbeat = now_ff;
                           state_in = S_EEV;
                        end
                     end
                     default: state_in = S_FIN;
                  endcase
               end
               OP_PAIR: begin
                  // room was checked on entry, so an add always succeeds here
                  if (!(found_ff && rd_entry.pstate == PS_COMPLETE)) begin
                     wr_en           = 1'b1;
                     wr_entry.pstate = PS_PENDING;
                     wr_entry.since  = now_ff;
                     if (!found_ff) count_in = count_ff + CNT_W'(1);
                     txtype_in = FT_REQ;
                     state_in  = S_ETX;
                  end
               end
               OP_REMOVE: begin
                  if (found_ff) state_in = S_SREAD;
                  else status_in = ST_NOT_FOUND;
               end
               default: state_in = S_FIN;
            endcase
         end
         S_SREAD: begin
            // shift later entries down by one, then drop the tail
            if (idx_next < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_next[IDX_W-1:0];
               state_in = S_SWR;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_FIN;
            end
         end
         S_SWR: begin
            wr_en    = 1'b1;
            wr_entry = rd_entry;
            idx_in   = idx_next;
            state_in = S_SREAD;
         end
         S_PREAD: begin
            if (idx_ff >= count_ff) begin
               state_in = S_FIN;
            end else begin
               rd_en    = 1'b1;
               state_in = S_PCHK;
            end
         end
         S_PCHK: begin
            if (rd_entry.pstate == PS_PENDING && age > tmo) begin
               wr_en           = 1'b1;
               wr_entry.pstate = PS_NONE;
               evaddr_in       = rd_entry.addr;
               evpaired_in     = 1'b0;
               state_in        = S_EEV;
            end else begin
               idx_in   = idx_next;
               state_in = S_PREAD;
            end
         end
         S_ETX: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               okind_in  = RK_TX;
               olast_in  = 1'b0;
               odata_in  = {14'd0, seq_ff, txtype_ff, key_ff};
               seq_in    = seq_ff + 8'd1;
               state_in  = doev_ff ? S_EEV : S_FIN;
            end
         end
         S_EEV: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               okind_in  = RK_EVENT;
               olast_in  = 1'b0;
               odata_in  = {5'd0, evpaired_ff, evaddr_ff, 18'd0};
               if (op_ff == OP_POLL) begin
                  idx_in   = idx_next;
                  state_in = S_PREAD;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               okind_in  = RK_STATUS;
               olast_in  = 1'b1;
               odata_in  = {2'd0, status_ff, 27'd0};
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         seq_ff     <= '0;
         ovalid_ff  <= 1'b0;
         role_ff    <= 1'b0;
         own_ff     <= 8'd0;
         timeout_ff <= 32'd0;
         limit_ff   <= 5'd16;
         amin_ff    <= 8'd1;
         amax_ff    <= 8'd254;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         seq_ff    <= seq_in;
         ovalid_ff <= ovalid_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_ROLE:    role_ff    <= csr_wdata[0];
               REG_OWN:     own_ff     <= csr_wdata[7:0];
               REG_TIMEOUT: timeout_ff <= csr_wdata;
               REG_LIMIT:   limit_ff   <= csr_wdata[4:0];
               REG_MIN:     amin_ff    <= csr_wdata[7:0];
               REG_MAX:     amax_ff    <= csr_wdata[7:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers: no reset needed
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      op_ff       <= op_in;
      ftype_ff    <= ftype_in;
      key_ff      <= key_in;
      now_ff      <= now_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      txtype_ff   <= txtype_in;
      doev_ff     <= doev_in;
      evaddr_ff   <= evaddr_in;
      evpaired_ff <= evpaired_in;
      odata_ff    <= odata_in;
      okind_ff    <= okind_in;
      olast_ff    <= olast_in;
   end
endmodule
`default_nettype wire
